[src/mtao_pkg.sv]
// Shared widths, command codes and parameter defaults for the max-tree
// area opening block. No dependencies.
`timescale 1ns / 1ps

package mtao_pkg;

  // Fixed widths of the port fields
  localparam int IDX_W  = 16;
  localparam int AREA_W = 17;
  localparam int GREY_W = 8;

  // Defaults for the top-level parameters
  localparam int unsigned NUM_PIXELS_DEF = 65536;
  localparam int unsigned GREY_BITS_DEF  = 8;

  // Command codes on the cmd field
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_FILTER = 1'b1;

endpackage

[src/mtao_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module mtao_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Hold the last read word while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/max_tree_area_opening.sv]
// Top level of the max-tree area opening: node RAM, mark RAM and the climb/mark
// sequencer. Depends on mtao_pkg and mtao_ram.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                  Word
// in        in   in_valid_i / in_stall_o    cmd, pixel_index, parent_index, node_area, grey_level
// out       out  out_valid_o / out_stall_i  filtered_value
// cfg       in   cfg_valid_i / cfg_ready_o  area_threshold
//
// A load is accepted in the idle state and leaves the sequencer idle. A filter climbs
// links from its pixel, each link through a climb state (parent read) and a test state
// (merge test), then retraces them through mark and next states, on one node RAM port.
// No reset sweep: the user must load every entry before it is read; the block does not
// enforce this. A finished word waits in the output register while the next item is
// accepted; a second finished filter waits until that word is taken.

module max_tree_area_opening #(
  parameter int unsigned NUM_PIXELS = mtao_pkg::NUM_PIXELS_DEF,
  parameter int unsigned GREY_BITS  = mtao_pkg::GREY_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [mtao_pkg::IDX_W-1:0]  pixel_index_i,
  input  logic [mtao_pkg::IDX_W-1:0]  parent_index_i,
  input  logic [mtao_pkg::AREA_W-1:0] node_area_i,
  input  logic [mtao_pkg::GREY_W-1:0] grey_level_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mtao_pkg::GREY_W-1:0] filtered_value_o,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mtao_pkg::AREA_W-1:0] cfg_area_threshold_i
);

  import mtao_pkg::*;

  localparam int AW     = $clog2(NUM_PIXELS);
  localparam int SW     = $clog2(NUM_PIXELS + 1);
  localparam int NODE_W = IDX_W + AREA_W + GREY_BITS;
  localparam int MARK_W = 1 + GREY_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLIMB = 3'd1;
  localparam logic [2:0] ST_TEST  = 3'd2;
  localparam logic [2:0] ST_MARK  = 3'd3;
  localparam logic [2:0] ST_NEXT  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [AW-1:0]        v_q, v_d;
  logic [AW-1:0]        w_q, w_d;
  logic [AW-1:0]        u_q, u_d;
  logic [SW-1:0]        steps_q, steps_d;
  logic [SW-1:0]        i_q, i_d;
  logic [IDX_W-1:0]     wpar_q, wpar_d;
  logic [AREA_W-1:0]    warea_q, warea_d;
  logic [GREY_BITS-1:0] wgrey_q, wgrey_d;
  logic [GREY_BITS-1:0] val_q, val_d;
  logic [AREA_W-1:0]    thr_q;
  logic                 out_valid_q, out_valid_d;
  logic [GREY_W-1:0]    out_data_q, out_data_d;

  // RAM ports
  logic                 node_we, node_re, mark_we, mark_re;
  logic [AW-1:0]        node_waddr, node_raddr, mark_waddr, mark_raddr;
  logic [NODE_W-1:0]    node_wdata, node_rdata;
  logic [MARK_W-1:0]    mark_wdata, mark_rdata;

  logic [IDX_W-1:0]     n_par;
  logic [AREA_W-1:0]    n_area;
  logic [GREY_BITS-1:0] n_grey;
  logic                 m_done;
  logic [GREY_BITS-1:0] m_res;

  logic in_acc, in_range, is_root, steps_ok, climb_on, merge;

  assign n_grey = node_rdata[GREY_BITS-1:0];
  assign n_area = node_rdata[GREY_BITS +: AREA_W];
  assign n_par  = node_rdata[GREY_BITS+AREA_W +: IDX_W];
  assign m_res  = mark_rdata[GREY_BITS-1:0];
  assign m_done = mark_rdata[GREY_BITS];

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_range    = (32'(pixel_index_i) < NUM_PIXELS);

  assign is_root  = (32'(n_par) == 32'(w_q)) || (32'(n_par) >= NUM_PIXELS);
  assign steps_ok = (32'(steps_q) < NUM_PIXELS);
  assign climb_on = steps_ok && !is_root && !m_done;
  assign merge    = (wgrey_q == n_grey) || (warea_q <= thr_q);

  always_comb begin
    state_d     = state_q;
    v_d         = v_q;
    w_d         = w_q;
    u_d         = u_q;
    steps_d     = steps_q;
    i_d         = i_q;
    wpar_d      = wpar_q;
    warea_d     = warea_q;
    wgrey_d     = wgrey_q;
    val_d       = val_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    node_we    = 1'b0;
    node_waddr = AW'(pixel_index_i);
    node_wdata = {parent_index_i, node_area_i, GREY_BITS'(grey_level_i)};
    node_re    = 1'b0;
    node_raddr = AW'(pixel_index_i);
    mark_we    = 1'b0;
    mark_waddr = u_q;
    mark_wdata = {1'b1, val_q};
    mark_re    = 1'b0;
    mark_raddr = AW'(pixel_index_i);

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (cmd_i == CMD_LOAD) begin
            if (in_range) begin
              node_we    = 1'b1;
              mark_we    = 1'b1;
              mark_waddr = AW'(pixel_index_i);
              mark_wdata = '0;
            end
          end else if (in_range) begin
            node_re = 1'b1;
            mark_re = 1'b1;
            v_d     = AW'(pixel_index_i);
            w_d     = AW'(pixel_index_i);
            steps_d = '0;
            state_d = ST_CLIMB;
          end else begin
            val_d   = '0;
            state_d = ST_OUT;
          end
        end
      end
      ST_CLIMB: begin
        // RAM words hold node w
        wpar_d  = n_par;
        warea_d = n_area;
        wgrey_d = n_grey;
        if (climb_on) begin
          node_re    = 1'b1;
          mark_re    = 1'b1;
          node_raddr = AW'(n_par);
          mark_raddr = AW'(n_par);
          state_d    = ST_TEST;
        end else begin
          if (m_done) begin
            val_d = m_res;
          end else if (n_area > thr_q) begin
            val_d = n_grey;
          end else begin
            val_d = '0;
          end
          u_d     = v_q;
          i_d     = '0;
          state_d = ST_MARK;
        end
      end
      ST_TEST: begin
        // RAM words hold the parent; they stay put for the next climb step
        if (merge) begin
          w_d     = AW'(wpar_q);
          steps_d = steps_q + 1'b1;
          state_d = ST_CLIMB;
        end else begin
          val_d   = (warea_q > thr_q) ? wgrey_q : '0;
          u_d     = v_q;
          i_d     = '0;
          state_d = ST_MARK;
        end
      end
      ST_MARK: begin
        mark_we = 1'b1;
        if (i_q < steps_q) begin
          mark_waddr = u_q;
          node_re    = 1'b1;
          node_raddr = u_q;
          state_d    = ST_NEXT;
        end else begin
          mark_waddr = w_q;
          state_d    = ST_OUT;
        end
      end
      ST_NEXT: begin
        u_d     = AW'(n_par);
        i_d     = i_q + 1'b1;
        state_d = ST_MARK;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = GREY_W'(val_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      thr_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_area_threshold_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q        <= v_d;
    w_q        <= w_d;
    u_q        <= u_d;
    steps_q    <= steps_d;
    i_q        <= i_d;
    wpar_q     <= wpar_d;
    warea_q    <= warea_d;
    wgrey_q    <= wgrey_d;
    val_q      <= val_d;
    out_data_q <= out_data_d;
  end

  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_data_q;

  // parent, area and grey of each node
  mtao_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NUM_PIXELS)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  // done mark and filtered result of each node
  mtao_ram #(
    .WIDTH (MARK_W),
    .DEPTH (NUM_PIXELS)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .re_i    (mark_re),
    .raddr_i (mark_raddr),
    .rdata_o (mark_rdata)
  );

endmodule

[src/mtao_checker.sv]
// Port-level checks for max_tree_area_opening, attached by bind.
// Depends on mtao_pkg.
`timescale 1ns / 1ps

module mtao_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        cmd_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [mtao_pkg::GREY_W-1:0] filtered_value_o
);

  import mtao_pkg::*;

  // Hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(filtered_value_o))
    else $error("stalled output word dropped or changed");

  // A load gives no word
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == CMD_LOAD && !out_valid_o |=> !out_valid_o)
    else $error("load produced an output word");

  // A load leaves the input ready for the next item
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == CMD_LOAD |=> !in_stall_o)
    else $error("input stalled after a load");

  // A filter occupies the sequencer
  a_filter_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == CMD_FILTER |=> in_stall_o)
    else $error("input not stalled after a filter");

endmodule

bind max_tree_area_opening mtao_checker u_mtao_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .cmd_i            (cmd_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .filtered_value_o (filtered_value_o)
);
